// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AST_IMP(lbl, ante, cons, msg)

`define AST_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- design/lsdt_pkg.sv -----
// ----------------------------------------------------------------------------
// lsdt_pkg
// Types and constants of the line side and depth tracker.
// ----------------------------------------------------------------------------
package lsdt_pkg;

    localparam int HIST_DEPTH = 4;
    localparam int HIST_IDX_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

    localparam logic [15:0] FULL_TURN = 16'd36000;
    localparam logic [15:0] HALF_TURN = 16'd18000;
    localparam logic [7:0]  DEPTH_MAX = 8'd200;

    localparam logic [14:0] JUMP_ANGLE_RST = 15'd9000;
    localparam logic [7:0]  JUMP_LIMIT_RST = 8'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JUMP_ANGLE = 2'd0,
        CFG_JUMP_LIMIT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] bisector;
        logic        bisector_present;
        logic [7:0]  line_size;
        logic        on_line;
        logic        fresh;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  depth;
        logic [15:0] angle_out;
        logic        angle_valid;
        logic        inside_res;
        logic        fresh_out;
    } t_out_req;

endpackage

// ----- design/line_side_depth_tracker.sv -----
// ----------------------------------------------------------------------------
// line_side_depth_tracker
// Tracks the inner/outer half of a line and reports depth and bisector.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall carries one sensor report per request;
// output channel o_out_valid / i_out_stall returns one result per report.
// A request is taken when valid is high and stall is low.
// After a report is taken, one shared angle-difference and compare unit
// checks it against one history entry per cycle, then the update state
// writes state and the output register. A report skips the compare pass off
// the line, with an empty history or an absent angle, and otherwise is checked
// against all N history entries, where N is the number of entries (at most 4).
// o_in_stall is high from the cycle after acceptance until the update.
// A new report may be accepted while the previous result still waits.
// If the receiver stalls, the update cycle waits until the output register
// frees, and the input stays stalled meanwhile.
// Reset (i_rst_n low, synchronous) empties the history, clears the jump
// counter, the side and the depth, and loads jump_angle 9000, jump_limit 2.
// Configuration writes (i_cfg_we) are taken at any edge; write only when idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_side_depth_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lsdt_pkg::t_in_req                 i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lsdt_pkg::t_out_req                o_out,
    input  logic                              i_cfg_we,
    input  logic [lsdt_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lsdt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lsdt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    t_state                 r_state;
    logic [14:0]            r_jump_angle;
    logic [7:0]             r_jump_limit;
    logic [15:0]            r_hist_a [HIST_DEPTH];
    logic                   r_hist_p [HIST_DEPTH];
    logic [HIST_CNT_W-1:0]  r_hist_cnt;
    logic [HIST_IDX_W-1:0]  r_idx;
    logic [7:0]             r_jc;
    logic                   r_inner;
    logic [7:0]             r_depth;
    logic                   r_jump;
    logic [15:0]            r_a;
    logic                   r_pres;
    logic [7:0]             r_size;
    logic                   r_on;
    logic                   r_fresh;
    logic                   r_out_valid;
    t_out_req               r_out;

    logic [15:0]            n_a;
    logic [7:0]             n_size;
    logic [15:0]            n_entry;
    logic [15:0]            n_raw;
    logic [15:0]            n_diff;
    logic                   n_close;
    logic                   n_last;
    logic [7:0]             n_jc;
    logic                   n_toggle;
    logic                   n_out_free;
    logic [15:0]            n_turned;
    logic                   n_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign n_accept    = i_in_valid && (r_state == S_IDLE);
    assign n_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_a      = (i_in.bisector >= FULL_TURN) ? (i_in.bisector - FULL_TURN) : i_in.bisector;
        n_size   = (i_in.line_size > DEPTH_MAX) ? DEPTH_MAX : i_in.line_size;
        n_entry  = r_hist_a[r_idx];
        n_raw    = (r_a >= n_entry) ? (r_a - n_entry) : (n_entry - r_a);
        n_diff   = (n_raw > HALF_TURN) ? (FULL_TURN - n_raw) : n_raw;
        n_close  = !r_hist_p[r_idx] || (n_diff <= {1'b0, r_jump_angle});
        n_last   = ((HIST_CNT_W'(r_idx) + HIST_CNT_W'(1)) == r_hist_cnt);
        n_jc     = (r_jump && (r_jc != 8'hFF)) ? (r_jc + 8'd1) : r_jc;
        n_toggle = (n_jc >= r_jump_limit);
        n_turned = (r_a >= HALF_TURN) ? (r_a - HALF_TURN) : (r_a + HALF_TURN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_jump_angle <= JUMP_ANGLE_RST;
            r_jump_limit <= JUMP_LIMIT_RST;
            r_hist_cnt   <= '0;
            r_jc         <= '0;
            r_inner      <= 1'b0;
            r_depth      <= '0;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_jump       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_JUMP_ANGLE: r_jump_angle <= i_cfg_data;
                    CFG_JUMP_LIMIT: r_jump_limit <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_a     <= n_a;
                        r_pres  <= i_in.bisector_present;
                        r_size  <= n_size;
                        r_on    <= i_in.on_line;
                        r_fresh <= i_in.fresh;
                        r_idx   <= '0;
                        r_jump  <= (r_hist_cnt != '0) && i_in.bisector_present;
                        if (i_in.on_line && i_in.bisector_present && (r_hist_cnt != '0)) begin
                            r_state <= S_CMP;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_CMP: begin
                    if (n_close) begin
                        r_jump <= 1'b0;
                    end
                    if (n_last) begin
                        r_state <= S_UPD;
                    end else begin
                        r_idx <= r_idx + HIST_IDX_W'(1);
                    end
                end
                S_UPD: begin
                    if (n_out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.angle_valid     <= r_pres;
                        r_out.fresh_out       <= r_fresh;
                        r_out.angle_out       <= r_pres ? r_a : 16'd0;
                        r_out.inside_res      <= r_inner;
                        r_out.depth           <= r_depth;
                        if (r_on) begin
                            r_jc <= n_jc;
                            if (!r_jump) begin
                                if (r_hist_cnt < HIST_CNT_W'(HIST_DEPTH)) begin
                                    r_hist_a[r_hist_cnt[HIST_IDX_W-1:0]] <= r_a;
                                    r_hist_p[r_hist_cnt[HIST_IDX_W-1:0]] <= r_pres;
                                    r_hist_cnt <= r_hist_cnt + HIST_CNT_W'(1);
                                end else begin
                                    for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                                        r_hist_a[i] <= r_hist_a[i+1];
                                        r_hist_p[i] <= r_hist_p[i+1];
                                    end
                                    r_hist_a[HIST_DEPTH-1] <= r_a;
                                    r_hist_p[HIST_DEPTH-1] <= r_pres;
                                end
                            end
                            if (n_toggle) begin
                                r_inner          <= !r_inner;
                                r_out.inside_res <= !r_inner;
                                r_jc             <= '0;
                                r_hist_a[0]      <= r_a;
                                r_hist_p[0]      <= r_pres;
                                r_hist_cnt       <= HIST_CNT_W'(1);
                                if (r_inner) begin
                                    r_depth     <= DEPTH_MAX - r_size;
                                    r_out.depth <= DEPTH_MAX - r_size;
                                end else begin
                                    r_depth         <= r_size;
                                    r_out.depth     <= r_size;
                                    r_out.angle_out <= r_pres ? n_turned : 16'd0;
                                end
                            end else if (r_inner) begin
                                r_depth         <= r_size;
                                r_out.depth     <= r_size;
                                r_out.angle_out <= r_pres ? n_turned : 16'd0;
                            end else begin
                                r_depth     <= DEPTH_MAX - r_size;
                                r_out.depth <= DEPTH_MAX - r_size;
                            end
                        end else begin
                            if (r_hist_cnt != '0) begin
                                r_depth     <= r_inner ? 8'd0 : DEPTH_MAX;
                                r_out.depth <= r_inner ? 8'd0 : DEPTH_MAX;
                            end
                            r_hist_cnt <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `AST_IMP(a_hist_bound, 1'b1, r_hist_cnt <= HIST_CNT_W'(HIST_DEPTH), "history count overflow")
    `AST_IMP(a_cmp_needs, r_state == S_CMP, r_on && r_pres && (r_hist_cnt != '0), "bad compare pass")
    `AST_NXT(a_upd_out, (r_state == S_UPD) && n_out_free, o_out_valid && !o_in_stall, "update lost")
    `AST_IMP(a_depth_max, o_out_valid, o_out.depth <= DEPTH_MAX, "depth above range")
    `AST_IMP(a_side_match, o_out_valid, o_out.inside_res == r_inner, "side mismatch")

endmodule

// ----- dv/line_side_depth_tracker_check.sv -----
// ----------------------------------------------------------------------------
// line_side_depth_tracker_check
// Watches the report and result channels and the register port of the line
// side and depth tracker. It keeps its own copy of the history, the jump
// counter, the side and the held depth. For every accepted report it works
// out the result, queues it, and compares each accepted result field by field
// against the oldest queued one.
// ----------------------------------------------------------------------------
module line_side_depth_tracker_check
    import lsdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_req               i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_req              i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int RESULT_SLOTS = 8;

    logic [15:0] hist_ang [HIST_DEPTH];
    logic        hist_pres [HIST_DEPTH];
    int          hist_len;
    logic [7:0]  jumps;
    logic        inner;
    logic [7:0]  depth_held;
    logic [14:0] jump_angle;
    logic [7:0]  jump_limit;

    t_out_req    result_q [RESULT_SLOTS];
    int          rd_ptr = 0;
    int          wr_ptr = 0;
    int          fails = 0;
    int          waiting = 0;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    function automatic logic [15:0] turn_gap(input logic [15:0] a, input logic [15:0] b);
        logic [15:0] d;
        d = (a >= b) ? a - b : b - a;
        return (d > HALF_TURN) ? FULL_TURN - d : d;
    endfunction

    function automatic void remember_angle(input logic [15:0] a, input logic pres);
        int i;
        if (hist_len < HIST_DEPTH) begin
            hist_ang[hist_len]  = a;
            hist_pres[hist_len] = pres;
            hist_len++;
        end else begin
            for (i = 0; i < HIST_DEPTH - 1; i++) begin
                hist_ang[i]  = hist_ang[i + 1];
                hist_pres[i] = hist_pres[i + 1];
            end
            hist_ang[HIST_DEPTH - 1]  = a;
            hist_pres[HIST_DEPTH - 1] = pres;
        end
    endfunction

    function automatic t_out_req track_report(input t_in_req r);
        t_out_req    res;
        logic [15:0] ang;
        logic [7:0]  sz;
        logic        jump;
        logic        flip;
        int          i;
        ang  = r.bisector % FULL_TURN;
        sz   = (r.line_size > DEPTH_MAX) ? DEPTH_MAX : r.line_size;
        flip = 1'b0;
        if (r.on_line) begin
            jump = (hist_len > 0) && r.bisector_present;
            for (i = 0; i < hist_len; i++) begin
                if (!hist_pres[i] || turn_gap(ang, hist_ang[i]) <= {1'b0, jump_angle})
                    jump = 1'b0;
            end
            if (jump) begin
                if (jumps != 8'd255)
                    jumps++;
            end else begin
                remember_angle(ang, r.bisector_present);
            end
            if (jumps >= jump_limit) begin
                if (inner) begin
                    depth_held = DEPTH_MAX - sz;
                end else begin
                    depth_held = sz;
                    flip = 1'b1;
                end
                inner        = ~inner;
                jumps        = '0;
                hist_ang[0]  = ang;
                hist_pres[0] = r.bisector_present;
                hist_len     = 1;
            end else if (inner) begin
                depth_held = sz;
                flip = 1'b1;
            end else begin
                depth_held = DEPTH_MAX - sz;
            end
        end else begin
            if (hist_len > 0)
                depth_held = inner ? 8'd0 : DEPTH_MAX;
            hist_len = 0;
        end
        if (!r.bisector_present)
            ang = '0;
        else if (flip)
            ang = (ang + HALF_TURN) % FULL_TURN;
        res.depth       = depth_held;
        res.angle_out   = ang;
        res.angle_valid = r.bisector_present;
        res.inside_res  = inner;
        res.fresh_out   = r.fresh;
        return res;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val,
                     act_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_req exp_res;
        if (!i_rst_n) begin
            hist_len   = 0;
            jumps      = '0;
            inner      = 1'b0;
            depth_held = '0;
            jump_angle = JUMP_ANGLE_RST;
            jump_limit = JUMP_LIMIT_RST;
            rd_ptr     = 0;
            wr_ptr     = 0;
            waiting    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_JUMP_ANGLE: jump_angle = i_cfg_data;
                    CFG_JUMP_LIMIT: jump_limit = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (waiting == 0) begin
                    $display("%0t: unexpected result, expected none actual %h", $time, i_out);
                    fails++;
                end else begin
                    exp_res = result_q[rd_ptr];
                    rd_ptr  = (rd_ptr + 1) % RESULT_SLOTS;
                    waiting--;
                    check_field("depth", exp_res.depth, i_out.depth);
                    check_field("angle_out", exp_res.angle_out, i_out.angle_out);
                    check_field("angle_valid", exp_res.angle_valid, i_out.angle_valid);
                    check_field("inside_res", exp_res.inside_res, i_out.inside_res);
                    check_field("fresh_out", exp_res.fresh_out, i_out.fresh_out);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_q[wr_ptr] = track_report(i_in);
                wr_ptr = (wr_ptr + 1) % RESULT_SLOTS;
                waiting++;
            end
        end
    end

endmodule

// ----- dv/line_side_depth_tracker_test.sv -----
// ----------------------------------------------------------------------------
// line_side_depth_tracker_test
// Drives sensor reports into the line side and depth tracker under random
// gaps and result stalls: a directed run over the field extremes and the
// absent-angle, empty-history, off-line and wrap-around cases, then phases of
// random line-following sequences under several jump settings, the extremes
// among them. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module line_side_depth_tracker_test;
    import lsdt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int MAX_WAIT        = 18;
    localparam int PHASES          = 8;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_req               i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_req              o_out;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int in_calm   = 0;
    int out_calm  = 0;
    int line_base = 0;

    int angle_set [PHASES] = '{4500, 0, 18000, 12000, 0, 1, 17999, 0};
    int limit_set [PHASES] = '{1, 255, 1, 3, 0, 2, 4, 0};

    line_side_depth_tracker i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    line_side_depth_tracker_check i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("line_side_depth_tracker regression: fail");
        $finish;
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic t_in_req mk(input int bis, input bit pres, input int size, input bit on,
                                   input bit fr);
        t_in_req r;
        r.bisector         = bis[15:0];
        r.bisector_present = pres;
        r.line_size        = size[7:0];
        r.on_line          = on;
        r.fresh            = fr;
        return r;
    endfunction

    // mostly steady following around a base angle, with turn-arounds and noise
    function automatic t_in_req pick_report(input int ja);
        int roll;
        int a;
        roll = $urandom_range(0, 99);
        a = line_base + int'($urandom_range(0, 2 * ja + 1000)) - ja - 500;
        if (roll < 25)
            a = line_base + int'(HALF_TURN) + int'($urandom_range(0, 2000)) - 1000;
        else if (roll < 30)
            a = roll[0] ? line_base + ja : line_base - ja;
        a = ((a % 36000) + 36000) % 36000;
        if (roll >= 30 && roll < 95 && $urandom_range(0, 3) == 0)
            line_base = a;
        if ($urandom_range(0, 9) == 0 && a < 29536)
            a += 36000;
        if (roll >= 95)
            a = $urandom_range(0, 65535);
        return mk(a, $urandom_range(0, 9) != 0, $urandom_range(0, 254),
                  $urandom_range(0, 19) != 0, $urandom_range(0, 1));
    endfunction

    task automatic send_report(input t_in_req r);
        int   gap;
        logic took;
        gap = draw_wait(in_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= r;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = !o_in_stall;
            @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int hold;
        logic took;
        forever begin
            hold = draw_wait(out_calm);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            took = 1'b0;
            while (!took) begin
                @(negedge i_clk);
                took = o_out_valid;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        t_in_req directed [$];
        int ph;
        int n;
        int ja;
        int jl;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{
            mk(12345, 1, 100, 0, 1), mk(0, 1, 0, 1, 0),       mk(18000, 1, 254, 1, 1),
            mk(9000, 1, 200, 1, 0),  mk(22500, 1, 201, 1, 1), mk(4500, 1, 50, 1, 1),
            mk(35999, 0, 128, 1, 0), mk(4500, 1, 127, 1, 1),  mk(65535, 1, 10, 1, 1),
            mk(36000, 1, 254, 1, 0), mk(32768, 1, 199, 1, 1), mk(13500, 1, 1, 1, 1),
            mk(0, 0, 0, 0, 0),       mk(35999, 1, 254, 0, 1), mk(100, 1, 30, 1, 1),
            mk(18100, 1, 31, 1, 0),  mk(18100, 1, 31, 0, 1),  mk(65535, 0, 255, 1, 1),
            mk(27100, 1, 77, 1, 0),  mk(9100, 1, 88, 1, 1),   mk(27100, 1, 99, 1, 1),
            mk(40000, 1, 150, 1, 0), mk(21999, 1, 254, 0, 0)
        };
        foreach (directed[i])
            send_report(directed[i]);

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            ja = angle_set[ph];
            jl = limit_set[ph];
            if (ph == PHASES - 1) begin
                ja = $urandom_range(0, 18000);
                jl = $urandom_range(1, 8);
            end
            write_reg(CFG_JUMP_ANGLE, ja[CFG_DATA_W-1:0]);
            write_reg(CFG_JUMP_LIMIT, jl[CFG_DATA_W-1:0]);
            if (ph == 3)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 32767)));
            line_base = $urandom_range(0, 35999);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_report(pick_report(ja));
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("line_side_depth_tracker regression: pass");
        else
            $display("line_side_depth_tracker regression: fail");
        $finish;
    end

endmodule
